/* sv/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by u8u16_decode and utf8_to_utf16_transcoder; no dependencies.
`default_nettype none

package u8u16_pkg;

  // Result codes carried on the status field
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_TERM    = 3'd1,
    ST_INVALID = 3'd2,
    ST_SURR    = 3'd3,
    ST_RANGE   = 3'd4
  } status_e;

  // Second-byte overlong check armed by an E0 or F0 lead
  typedef enum logic [1:0] {
    OVL_NONE = 2'd0,
    OVL_E0   = 2'd1,
    OVL_F0   = 2'd2
  } ovl_e;

  // One result item
  typedef struct packed {
    logic [15:0] unit;
    status_e     status;
    logic        last;
  } res_t;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]  pending;
    logic [20:0] partial;
    ovl_e        ovl;
    logic [16:0] count;
    logic        disc;
  } dec_state_t;

  localparam int unsigned MaxRes   = 3;  // results one byte can cause
  localparam int unsigned ResDepth = 4;  // result queue entries (power of two)

  localparam logic [15:0] LimitReset = 16'd253;

  // Register index of unit_limit on the configuration port
  localparam logic RegUnitLimit = 1'b0;

endpackage

`default_nettype wire

/* sv/utf8_to_utf16_transcoder.sv */
// Streaming UTF-8 to UTF-16 transcoder: top level with config register,
// decoder state and result queue. Depends on u8u16_pkg and u8u16_decode.
//
// One UTF-8 byte is taken per cycle while the queue has room, decoded in the
// same cycle against the stored sequence state; its results land in a
// four-entry result queue whose head drives the output port, so results are
// registered. The queue drains one result per cycle unless the output stalls:
// a byte causing at most one result is taken every cycle if out_stall_i is low,
// while a byte causing two or three (a surrogate pair, a pair plus a truncation
// terminator) stalls input as it drains. unit_limit sits at byte address 0.
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // Unit output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] unit_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntW = $clog2(ResDepth + 1);

  logic [15:0]       limit_q;
  dec_state_t        st_q;
  dec_state_t        st_d;
  logic [1:0]        dec_num;
  res_t [MaxRes-1:0] dec_res;

  res_t              q_q [ResDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cnt_d;
  logic              in_acc;
  logic              out_acc;
  logic [1:0]        push_n;
  logic              reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegUnitLimit);
  assign prdata  = reg_sel ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[15:0];
    end
  end

  // Decode
  u8u16_decode u_dec (
    .cur_i   (st_q),
    .byte_i  (in_byte_i),
    .limit_i (limit_q),
    .nxt_o   (st_d),
    .num_o   (dec_num),
    .res_o   (dec_res)
  );

  // Hold input unless the queue has room for a worst-case byte
  assign in_stall_o = (cnt_q > CntW'(ResDepth - MaxRes));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign push_n     = in_acc ? dec_num : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // Result queue: push up to three, pop one
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (k < int'(push_n)) begin
        q_q[wr_ptr_q + PtrW'(k)] <= dec_res[k];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q + CntW'(push_n) - (out_acc ? CntW'(1) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Drive the head entry
  assign unit_o   = q_q[rd_ptr_q].unit;
  assign status_o = q_q[rd_ptr_q].status;
  assign last_o   = q_q[rd_ptr_q].last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ResDepth))
    else $error("result queue overfilled");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (cnt_q + CntW'(dec_num) <= CntW'(ResDepth)))
    else $error("byte accepted without room for its results");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q.disc) |-> (dec_num == 2'd0))
    else $error("result produced while skipping a string");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dec_num != 2'd0) |-> dec_res[dec_num - 2'd1].last)
    else $error("final result of a byte not marked last");

endmodule

`default_nettype wire

/* sv/u8u16_decode.sv */
// Combinational UTF-8 byte decoder: next state and up to three results.
// Depends on u8u16_pkg for the state and result types.
`default_nettype none

module u8u16_decode
  import u8u16_pkg::*;
(
  input  dec_state_t            cur_i,
  input  logic [7:0]            byte_i,
  input  logic [15:0]           limit_i,
  output dec_state_t            nxt_o,
  output logic [1:0]            num_o,
  output res_t [MaxRes-1:0]     res_o
);

  logic [20:0] cp;
  logic [20:0] pp;
  logic [20:0] v;
  logic [17:0] sum;
  logic [16:0] new_cnt;
  logic        have_cp;
  logic        fail;
  status_e     fail_code;
  logic [1:0]  n;

  always_comb begin
    nxt_o     = cur_i;
    res_o     = '0;
    n         = 2'd0;
    cp        = '0;
    pp        = '0;
    v         = '0;
    sum       = '0;
    new_cnt   = '0;
    have_cp   = 1'b0;
    fail      = 1'b0;
    fail_code = ST_INVALID;

    if (cur_i.disc) begin
      // Skip to the end of the string, then start fresh
      if (byte_i == 8'h00) begin
        nxt_o.disc    = 1'b0;
        nxt_o.pending = '0;
        nxt_o.partial = '0;
        nxt_o.ovl     = OVL_NONE;
        nxt_o.count   = '0;
      end
    end else if (cur_i.pending == 2'd0) begin
      // Lead position
      if (byte_i == 8'h00) begin
        res_o[0].status = ST_TERM;
        res_o[0].last   = 1'b1;
        n               = 2'd1;
        nxt_o.pending   = '0;
        nxt_o.partial   = '0;
        nxt_o.ovl       = OVL_NONE;
        nxt_o.count     = '0;
      end else if (byte_i < 8'h80) begin
        cp      = {13'd0, byte_i};
        have_cp = 1'b1;
      end else if (byte_i < 8'hC2 || byte_i >= 8'hF8) begin
        fail = 1'b1;
      end else if (byte_i < 8'hE0) begin
        nxt_o.partial = {16'd0, byte_i[4:0]};
        nxt_o.pending = 2'd1;
      end else if (byte_i < 8'hF0) begin
        nxt_o.partial = {17'd0, byte_i[3:0]};
        nxt_o.pending = 2'd2;
        nxt_o.ovl     = (byte_i == 8'hE0) ? OVL_E0 : OVL_NONE;
      end else begin
        nxt_o.partial = {18'd0, byte_i[2:0]};
        nxt_o.pending = 2'd3;
        nxt_o.ovl     = (byte_i == 8'hF0) ? OVL_F0 : OVL_NONE;
      end
    end else begin
      // Continuation position
      if (byte_i[7:6] != 2'b10) begin
        fail = 1'b1;
      end else if (cur_i.ovl == OVL_E0 && byte_i[5] == 1'b0) begin
        fail = 1'b1;
      end else if (cur_i.ovl == OVL_F0 && byte_i[5:4] == 2'b00) begin
        fail = 1'b1;
      end else begin
        pp            = {cur_i.partial[14:0], byte_i[5:0]};
        nxt_o.ovl     = OVL_NONE;
        nxt_o.partial = pp;
        nxt_o.pending = cur_i.pending - 2'd1;
        if (cur_i.pending == 2'd1) begin
          cp      = pp;
          have_cp = 1'b1;
        end
      end
    end

    // Range checks on a finished code point
    if (have_cp) begin
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
        fail      = 1'b1;
        fail_code = ST_SURR;
      end else if (cp > 21'h10FFFF) begin
        fail      = 1'b1;
        fail_code = ST_RANGE;
      end else begin
        // Emit one unit or a surrogate pair
        if (cp <= 21'h00FFFF) begin
          res_o[0].unit   = cp[15:0];
          res_o[0].status = ST_DATA;
          sum             = {1'b0, cur_i.count} + 18'd1;
          n               = 2'd1;
        end else begin
          v               = cp - 21'h010000;
          res_o[0].unit   = 16'hD800 + {6'd0, v[19:10]};
          res_o[0].status = ST_DATA;
          res_o[1].unit   = 16'hDC00 + {6'd0, v[9:0]};
          res_o[1].status = ST_DATA;
          sum             = {1'b0, cur_i.count} + 18'd2;
          n               = 2'd2;
        end
        new_cnt       = sum[17] ? 17'h1FFFF : sum[16:0];
        nxt_o.pending = '0;
        nxt_o.partial = '0;
        nxt_o.ovl     = OVL_NONE;
        nxt_o.count   = new_cnt;
        // Truncate once the limit is reached
        if (new_cnt >= {1'b0, limit_i}) begin
          res_o[n].status = ST_TERM;
          nxt_o.count     = '0;
          nxt_o.disc      = 1'b1;
          n               = n + 2'd1;
        end
        res_o[n - 2'd1].last = 1'b1;
      end
    end

    // Error: one result, then skip to the NUL unless this byte is the NUL
    if (fail) begin
      res_o         = '0;
      res_o[0].status = fail_code;
      res_o[0].last = 1'b1;
      n             = 2'd1;
      nxt_o.pending = '0;
      nxt_o.partial = '0;
      nxt_o.ovl     = OVL_NONE;
      nxt_o.count   = '0;
      nxt_o.disc    = (byte_i != 8'h00);
    end

    num_o = n;
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for utf8_to_utf16_transcoder: directed byte table, then
// random UTF-8 strings under several unit limits. Needs only u8u16_pkg and the RTL.

module tb;
  import u8u16_pkg::*;

  // Directed stimulus row; typed rows carry the single result they must cause
  typedef struct {
    logic [7:0]  data;
    bit          typed;
    logic [15:0] unit;
    status_e     status;
  } row_t;

  localparam int DirRows = 26;
  localparam int ItemsPerPhase = 46;
  localparam int LongHoldCycles = 60;
  localparam int SettleCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] unit_o;
  logic [2:0]  status_o;
  logic        last_o;

  // Side-band of the byte on the input port: its typed result, if any
  bit   byte_typed = 1'b0;
  res_t byte_want = '0;

  // Transcoder state as predicted by the bench
  logic [1:0]  seq_pend = '0;
  logic [20:0] seq_part = '0;
  ovl_e        seq_ovl = OVL_NONE;
  logic [16:0] str_units = '0;
  bit          skip_str = 1'b0;
  logic [15:0] lim_units = LimitReset;

  res_t step_res [3];
  int   step_n;
  res_t exp_units_q [$];
  int   fail_count = 0;
  int   sent_items = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   hold_req = 1'b0;

  row_t dir_tbl [DirRows] = '{
    '{8'h00, 1'b1, 16'h0000, ST_TERM},
    '{8'h7F, 1'b1, 16'h007F, ST_DATA},
    '{8'h80, 1'b1, 16'h0000, ST_INVALID},
    '{8'h00, 1'b0, 16'h0000, ST_DATA},
    '{8'hFF, 1'b1, 16'h0000, ST_INVALID},
    '{8'h00, 1'b0, 16'h0000, ST_DATA},
    '{8'hC2, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b0, 16'h0000, ST_DATA},
    '{8'hE0, 1'b0, 16'h0000, ST_DATA},
    '{8'h9F, 1'b1, 16'h0000, ST_INVALID},
    '{8'h00, 1'b0, 16'h0000, ST_DATA},
    '{8'hED, 1'b0, 16'h0000, ST_DATA},
    '{8'hA0, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b1, 16'h0000, ST_SURR},
    '{8'h00, 1'b0, 16'h0000, ST_DATA},
    '{8'hF0, 1'b0, 16'h0000, ST_DATA},
    '{8'h90, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b0, 16'h0000, ST_DATA},
    '{8'hF4, 1'b0, 16'h0000, ST_DATA},
    '{8'h90, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b0, 16'h0000, ST_DATA},
    '{8'h80, 1'b1, 16'h0000, ST_RANGE},
    '{8'h00, 1'b0, 16'h0000, ST_DATA},
    '{8'hC2, 1'b0, 16'h0000, ST_DATA},
    '{8'h00, 1'b1, 16'h0000, ST_INVALID}
  };

  logic [15:0] phase_lim [4] = '{16'd1, 16'd3, 16'hFFFF, 16'd2};

  utf8_to_utf16_transcoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .unit_o     (unit_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decode one byte against the predicted state; results land in step_res
  function automatic void predict_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic [19:0] off;
    status_e     code;
    bit          bad;
    step_n = 0;
    bad = 1'b0;
    code = ST_INVALID;
    cp = '0;
    // Skip the rest of a failed or truncated string up to its NUL
    if (skip_str) begin
      if (b == 8'h00) begin
        skip_str = 1'b0;
        seq_pend = '0;
        seq_part = '0;
        seq_ovl = OVL_NONE;
        str_units = '0;
      end
      return;
    end
    if (seq_pend == 2'd0) begin
      if (b == 8'h00) begin
        step_res[0] = '{16'h0000, ST_TERM, 1'b1};
        step_n = 1;
        seq_part = '0;
        seq_ovl = OVL_NONE;
        str_units = '0;
        return;
      end
      if (b < 8'h80) begin
        cp = {13'h0, b};
      end else if (b < 8'hC2 || b >= 8'hF8) begin
        bad = 1'b1;
      end else if (b < 8'hE0) begin
        seq_part = {16'h0, b[4:0]};
        seq_pend = 2'd1;
        return;
      end else if (b < 8'hF0) begin
        seq_part = {17'h0, b[3:0]};
        seq_pend = 2'd2;
        seq_ovl = (b == 8'hE0) ? OVL_E0 : OVL_NONE;
        return;
      end else begin
        seq_part = {18'h0, b[2:0]};
        seq_pend = 2'd3;
        seq_ovl = (b == 8'hF0) ? OVL_F0 : OVL_NONE;
        return;
      end
    end else if (b[7:6] != 2'b10 || (seq_ovl == OVL_E0 && !b[5]) ||
                 (seq_ovl == OVL_F0 && b[5:4] == 2'b00)) begin
      bad = 1'b1;
    end else begin
      // Accumulate six more bits; hold until the sequence completes
      seq_ovl = OVL_NONE;
      seq_part = {seq_part[14:0], b[5:0]};
      seq_pend = seq_pend - 2'd1;
      if (seq_pend != 2'd0) return;
      cp = seq_part;
    end

    if (!bad && cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
      bad = 1'b1;
      code = ST_SURR;
    end else if (!bad && cp > 21'h10FFFF) begin
      bad = 1'b1;
      code = ST_RANGE;
    end
    seq_pend = '0;
    seq_part = '0;
    seq_ovl = OVL_NONE;

    if (bad) begin
      step_res[0] = '{16'h0000, code, 1'b1};
      step_n = 1;
      str_units = '0;
      skip_str = (b != 8'h00);
      return;
    end

    // Emit one unit in the BMP, else a surrogate pair
    if (cp <= 21'h00FFFF) begin
      step_res[0] = '{cp[15:0], ST_DATA, 1'b0};
      step_n = 1;
      str_units = str_units + 17'd1;
    end else begin
      off = cp[19:0] - 20'h10000;
      step_res[0] = '{16'hD800 + {6'h0, off[19:10]}, ST_DATA, 1'b0};
      step_res[1] = '{16'hDC00 + {6'h0, off[9:0]}, ST_DATA, 1'b0};
      step_n = 2;
      str_units = str_units + 17'd2;
    end

    // Truncate and terminate once the string reaches the limit
    if (str_units >= {1'b0, lim_units}) begin
      step_res[step_n] = '{16'h0000, ST_TERM, 1'b0};
      step_n++;
      str_units = '0;
      skip_str = 1'b1;
    end
    step_res[step_n - 1].last = 1'b1;
  endfunction

  // Check each accepted result, then predict for each accepted byte
  always @(posedge clk_i) begin : track
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_units_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: unit=%h status=%0d last=%b",
                     unit_o, status_o, last_o);
        end else begin
          want = exp_units_q.pop_front();
          if (unit_o !== want.unit || status_o !== want.status || last_o !== want.last)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected unit=%h status=%0d last=%b,",
                        " got unit=%h status=%0d last=%b"},
                       want.unit, want.status, want.last, unit_o, status_o, last_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        sent_items++;
        predict_byte(in_byte_i);
        if (byte_typed) begin
          exp_units_q.push_back(byte_want);
        end else begin
          for (int k = 0; k < step_n; k++) exp_units_q.push_back(step_res[k]);
        end
      end
    end
  end

  // Offer one byte after a random gap; return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input res_t want = '0);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    byte_typed <= typed;
    byte_want <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Send one string of random code points, mostly well formed, ending in NUL
  task automatic send_string();
    int unsigned npts;
    int unsigned roll;
    logic [7:0]  lead;
    npts = $urandom_range(0, 6);
    repeat (npts) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_byte(8'($urandom_range(1, 127)));
      end else if (roll < 50) begin
        send_byte(8'($urandom_range(8'hC2, 8'hDF)));
        send_byte(cont_byte());
      end else if (roll < 70) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        send_byte(lead);
        if (lead == 8'hE0) send_byte(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == 8'hED) send_byte(8'($urandom_range(8'h80, 8'h9F)));
        else send_byte(cont_byte());
        send_byte(cont_byte());
      end else if (roll < 88) begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        send_byte(lead);
        if (lead == 8'hF0) send_byte(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == 8'hF4) send_byte(8'($urandom_range(8'h80, 8'h8F)));
        else send_byte(cont_byte());
        send_byte(cont_byte());
        send_byte(cont_byte());
      end else begin
        // Broken sequences and noise
        case ($urandom_range(0, 5))
          0: begin
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(8'h80, 8'hC1)));
            else send_byte(8'($urandom_range(8'hF8, 8'hFF)));
          end
          1: begin
            if ($urandom_range(0, 1) == 0) begin
              send_byte(8'hE0);
              send_byte(8'($urandom_range(8'h80, 8'h9F)));
            end else begin
              send_byte(8'hF0);
              send_byte(8'($urandom_range(8'h80, 8'h8F)));
            end
            send_byte(cont_byte());
          end
          2: begin
            send_byte(8'hED);
            send_byte(8'($urandom_range(8'hA0, 8'hBF)));
            send_byte(cont_byte());
          end
          3: begin
            if ($urandom_range(0, 1) == 0) begin
              send_byte(8'hF4);
              send_byte(8'($urandom_range(8'h90, 8'hBF)));
            end else begin
              send_byte(8'($urandom_range(8'hF5, 8'hF7)));
              send_byte(cont_byte());
            end
            send_byte(cont_byte());
            send_byte(cont_byte());
          end
          4: begin
            send_byte(8'($urandom_range(8'hC2, 8'hF4)));
            if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 8'h7F)));
            else send_byte(8'($urandom_range(8'hC0, 8'hFF)));
          end
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
    send_byte(8'h00);
  endtask

  // Write unit_limit through the config port; the block must be idle
  task automatic write_unit_limit(input logic [15:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegUnitLimit, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lim_units = val;
  endtask

  // Drop valid, drain every expected result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (exp_units_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Receiver: random stall per result, bursts without stalls, one long hold
  initial begin : rx_side
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stim
    int start;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset limit
    for (int i = 0; i < DirRows; i++) begin
      send_byte(dir_tbl[i].data, dir_tbl[i].typed,
                '{dir_tbl[i].unit, dir_tbl[i].status, 1'b1});
    end
    settle();

    // Random strings under several limits, extremes included
    for (int p = 0; p < 4; p++) begin
      write_unit_limit(phase_lim[p]);
      if (p == 1) hold_req = 1'b1;
      start = sent_items;
      while (sent_items - start < ItemsPerPhase) send_string();
      settle();
    end

    if (fail_count == 0 && exp_units_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
